// ----- rtl/gbst_pkg.sv -----
package gbst_pkg;

	localparam int IDX_W   = 12;
	localparam int ACT_W   = 2;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [ACT_W-1:0] ACT_MAP   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_OFFER = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_MAX_MODE = 1'b0;

endpackage

// ----- rtl/gbst_ram.sv -----
module gbst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/grouped_best_score_table.sv -----
// Flow: a score offer reads the map memory in S_LOOK; for a mapped item the group entry is
// compared and written back in S_UPD. An unmapped offer goes to S_FIN, a group read passes
// S_RD first, and a map write or unused action goes straight to S_FIN, where the result is
// registered and held until transfer. One item at a time: input is taken only in S_IDLE.
// Reset: max_mode returns to 1 and a clearing pass over max(item depth, group depth) addresses
// (4096 at the defaults) zeroes both memories; no input is taken until it ends.
module grouped_best_score_table #(
	parameter int MAX_ITEMS  = 4096,
	parameter int MAX_GROUPS = 4096,
	parameter int SCORE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gbst_pkg::PADDR_W-1:0]        paddr,
	input  logic [gbst_pkg::PDATA_W-1:0]        pwdata,
	output logic [gbst_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gbst_pkg::ACT_W-1:0]          action,
	input  logic [gbst_pkg::IDX_W-1:0]          item_index,
	input  logic [gbst_pkg::IDX_W-1:0]          group_index,
	input  logic signed [SCORE_BITS-1:0]        score_value,
	input  logic [gbst_pkg::IDX_W-1:0]          source_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                entry_filled,
	output logic                                replaced,
	output logic signed [SCORE_BITS-1:0]        best_score,
	output logic [gbst_pkg::IDX_W-1:0]          best_item,
	output logic [gbst_pkg::IDX_W-1:0]          best_source
);

	import gbst_pkg::*;

	localparam int IDX_SPAN    = 1 << IDX_W;
	localparam int ITEM_DEPTH  = (MAX_ITEMS < IDX_SPAN) ? MAX_ITEMS : IDX_SPAN;
	localparam int GROUP_DEPTH = (MAX_GROUPS < IDX_SPAN) ? MAX_GROUPS : IDX_SPAN;
	localparam int CLR_DEPTH   = (ITEM_DEPTH > GROUP_DEPTH) ? ITEM_DEPTH : GROUP_DEPTH;
	localparam int IA_W        = $clog2(ITEM_DEPTH);
	localparam int GA_W        = $clog2(GROUP_DEPTH);
	localparam int CW          = $clog2(CLR_DEPTH);
	localparam int MW          = 1 + GA_W;
	localparam int GW          = 1 + SCORE_BITS + 2 * IDX_W;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_LOOK = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0]             state_q, state_d;
	logic [CW-1:0]          clr_cnt_q;
	logic                   max_mode_q;

	logic [IDX_W-1:0]       item_q, src_q;
	logic signed [SCORE_BITS-1:0] score_q;
	logic                   item_ok_q, grp_ok_q;
	logic [GA_W-1:0]        grp_addr_q;

	logic                   res_filled_q, res_repl_q;
	logic signed [SCORE_BITS-1:0] res_score_q;
	logic [IDX_W-1:0]       res_item_q, res_src_q;

	logic                   out_valid_q, out_filled_q, out_repl_q;
	logic signed [SCORE_BITS-1:0] out_score_q;
	logic [IDX_W-1:0]       out_item_q, out_src_q;

	logic                   in_fire, item_ok, grp_ok, clr_active, cfg_wr, out_load;
	logic                   map_we, grp_we;
	logic [IA_W-1:0]        map_waddr;
	logic [MW-1:0]          map_wdata, map_rdata;
	logic [GA_W-1:0]        grp_waddr, grp_raddr;
	logic [GW-1:0]          grp_wdata, grp_rdata;

	logic                   ent_filled;
	logic signed [SCORE_BITS-1:0] ent_score;
	logic [IDX_W-1:0]       ent_item, ent_src;
	logic                   better, take;

	gbst_ram #(.WIDTH(MW), .DEPTH(ITEM_DEPTH)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (item_index[IA_W-1:0]),
		.rdata (map_rdata)
	);

	gbst_ram #(.WIDTH(GW), .DEPTH(GROUP_DEPTH)) u_grp_ram (
		.clk   (clk),
		.we    (grp_we),
		.waddr (grp_waddr),
		.wdata (grp_wdata),
		.raddr (grp_raddr),
		.rdata (grp_rdata)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_MAX_MODE) ? {{(PDATA_W-1){1'b0}}, max_mode_q} : '0;

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign item_ok    = (32'(item_index) < MAX_ITEMS);
	assign grp_ok     = (32'(group_index) < MAX_GROUPS);
	assign clr_active = (state_q == S_CLR);
	assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign {ent_filled, ent_score, ent_item, ent_src} = grp_rdata;

	assign better = max_mode_q ? (score_q > ent_score) : (score_q < ent_score);
	assign take   = !ent_filled || better;

	// map memory: clearing pass, or a mapping write at the input transfer
	always_comb begin
		map_we    = 1'b0;
		map_waddr = item_index[IA_W-1:0];
		map_wdata = {1'b1, group_index[GA_W-1:0]};
		if (clr_active) begin
			map_we    = (32'(clr_cnt_q) < ITEM_DEPTH);
			map_waddr = clr_cnt_q[IA_W-1:0];
			map_wdata = '0;
		end else if (in_fire && action == ACT_MAP) begin
			map_we = item_ok && grp_ok;
		end
	end

	// group memory: clearing pass, or write-back of a first or better score
	always_comb begin
		grp_we    = 1'b0;
		grp_waddr = grp_addr_q;
		grp_wdata = {1'b1, score_q, item_q, src_q};
		if (clr_active) begin
			grp_we    = (32'(clr_cnt_q) < GROUP_DEPTH);
			grp_waddr = clr_cnt_q[GA_W-1:0];
			grp_wdata = '0;
		end else if (state_q == S_UPD) begin
			grp_we = take;
		end
	end

	assign grp_raddr = (state_q == S_LOOK) ? map_rdata[GA_W-1:0] : group_index[GA_W-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (clr_cnt_q == CW'(CLR_DEPTH - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_fire) begin
					case (action)
						ACT_OFFER: state_d = S_LOOK;
						ACT_READ:  state_d = S_RD;
						default:   state_d = S_FIN;
					endcase
				end
			end
			S_LOOK: begin
				state_d = (item_ok_q && map_rdata[MW-1]) ? S_UPD : S_FIN;
			end
			S_RD:  state_d = S_FIN;
			S_UPD: state_d = S_FIN;
			S_FIN: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_cnt_q   <= '0;
			max_mode_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_active) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cfg_wr && paddr[2] == REG_MAX_MODE) begin
				max_mode_q <= pwdata[0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q       <= item_index;
			src_q        <= source_index;
			score_q      <= score_value;
			item_ok_q    <= item_ok;
			grp_ok_q     <= grp_ok;
			res_filled_q <= 1'b0;
			res_repl_q   <= 1'b0;
			res_score_q  <= '0;
			res_item_q   <= '0;
			res_src_q    <= '0;
		end
		if (state_q == S_LOOK) begin
			grp_addr_q <= map_rdata[GA_W-1:0];
		end
		if (state_q == S_RD && grp_ok_q && ent_filled) begin
			res_filled_q <= 1'b1;
			res_score_q  <= ent_score;
			res_item_q   <= ent_item;
			res_src_q    <= ent_src;
		end
		if (state_q == S_UPD) begin
			res_filled_q <= 1'b1;
			res_repl_q   <= take;
			res_score_q  <= take ? score_q : ent_score;
			res_item_q   <= take ? item_q : ent_item;
			res_src_q    <= take ? src_q : ent_src;
		end
		if (out_load) begin
			out_filled_q <= res_filled_q;
			out_repl_q   <= res_repl_q;
			out_score_q  <= res_score_q;
			out_item_q   <= res_item_q;
			out_src_q    <= res_src_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign entry_filled = out_filled_q;
	assign replaced     = out_repl_q;
	assign best_score   = out_score_q;
	assign best_item    = out_item_q;
	assign best_source  = out_src_q;

endmodule

// ----- test/gbst_checker.sv -----
`timescale 1ns / 1ps

module gbst_checker #(
	parameter int ITEM_DEPTH  = 4096,
	parameter int GROUP_DEPTH = 4096,
	parameter int SCORE_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gbst_pkg::PADDR_W-1:0]      paddr,
	input  logic [gbst_pkg::PDATA_W-1:0]      pwdata,
	input  logic                              pready,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [gbst_pkg::ACT_W-1:0]        action,
	input  logic [gbst_pkg::IDX_W-1:0]        item_index,
	input  logic [gbst_pkg::IDX_W-1:0]        group_index,
	input  logic signed [SCORE_BITS-1:0]      score_value,
	input  logic [gbst_pkg::IDX_W-1:0]        source_index,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              entry_filled,
	input  logic                              replaced,
	input  logic signed [SCORE_BITS-1:0]      best_score,
	input  logic [gbst_pkg::IDX_W-1:0]        best_item,
	input  logic [gbst_pkg::IDX_W-1:0]        best_source,
	output int                                fail_count,
	output int                                pending_count,
	output int                                checked_count
);

	import gbst_pkg::*;

	typedef struct packed {
		logic                  filled;
		logic                  replaced;
		logic [SCORE_BITS-1:0] score;
		logic [IDX_W-1:0]      item;
		logic [IDX_W-1:0]      source;
	} entry_t;

	logic                         keep_max;
	bit                           item_mapped [ITEM_DEPTH];
	logic [IDX_W-1:0]             item_group  [ITEM_DEPTH];
	bit                           group_held  [GROUP_DEPTH];
	logic signed [SCORE_BITS-1:0] held_score  [GROUP_DEPTH];
	logic [IDX_W-1:0]             held_item   [GROUP_DEPTH];
	logic [IDX_W-1:0]             held_source [GROUP_DEPTH];

	entry_t outstanding_entries [$];
	int     fails;
	int     checks;

	function automatic entry_t apply_item(input logic [ACT_W-1:0] act,
			input logic [IDX_W-1:0] item, input logic [IDX_W-1:0] group,
			input logic signed [SCORE_BITS-1:0] score, input logic [IDX_W-1:0] source);
		entry_t           res;
		logic [IDX_W-1:0] g;
		logic             take;
		res = '0;
		case (act)
			ACT_MAP: begin
				if (item < ITEM_DEPTH && group < GROUP_DEPTH) begin
					item_mapped[item] = 1'b1;
					item_group[item]  = group;
				end
			end
			ACT_OFFER: begin
				if (item < ITEM_DEPTH && item_mapped[item]) begin
					g = item_group[item];
					// ties keep the earlier entry
					if (!group_held[g])
						take = 1'b1;
					else if (keep_max)
						take = score > held_score[g];
					else
						take = score < held_score[g];
					if (take) begin
						group_held[g]  = 1'b1;
						held_score[g]  = score;
						held_item[g]   = item;
						held_source[g] = source;
					end
					res.filled   = 1'b1;
					res.replaced = take;
					res.score    = held_score[g];
					res.item     = held_item[g];
					res.source   = held_source[g];
				end
			end
			ACT_READ: begin
				if (group < GROUP_DEPTH && group_held[group]) begin
					res.filled = 1'b1;
					res.score  = held_score[group];
					res.item   = held_item[group];
					res.source = held_source[group];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		entry_t want;
		if (!arst_n) begin
			keep_max = 1'b1;
			for (int i = 0; i < ITEM_DEPTH; i++) begin
				item_mapped[i] = 1'b0;
				item_group[i]  = '0;
			end
			for (int i = 0; i < GROUP_DEPTH; i++) begin
				group_held[i]  = 1'b0;
				held_score[i]  = '0;
				held_item[i]   = '0;
				held_source[i] = '0;
			end
			outstanding_entries.delete();
			pending_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_MODE)
				keep_max = pwdata[0];
			if (out_valid && out_ready) begin
				if (outstanding_entries.size() == 0) begin
					$error("result transfer with no entry outstanding");
					fails++;
				end else begin
					want = outstanding_entries.pop_front();
					check_field("entry_filled", want.filled, entry_filled);
					check_field("replaced", want.replaced, replaced);
					check_field("best_score", $signed(want.score), best_score);
					check_field("best_item", want.item, best_item);
					check_field("best_source", want.source, best_source);
					checks++;
				end
			end
			if (in_valid && in_ready)
				outstanding_entries.push_back(apply_item(action, item_index, group_index,
						score_value, source_index));
			pending_count <= outstanding_entries.size();
			fail_count    <= fails;
			checked_count <= checks;
		end
	end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	import gbst_pkg::*;

	localparam int ITEM_DEPTH   = 4096;
	localparam int GROUP_DEPTH  = 4096;
	localparam int SCORE_BITS   = 16;
	localparam int PHASE_ITEMS  = 200;
	localparam int PHASES       = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 400;

	localparam logic [ACT_W-1:0]   ACT_UNUSED = 2'd3;
	localparam logic [PADDR_W-1:0] MODE_ADDR  = {REG_MAX_MODE, 2'b00};

	localparam logic signed [SCORE_BITS-1:0] SCORE_TOP    = {1'b0, {(SCORE_BITS-1){1'b1}}};
	localparam logic signed [SCORE_BITS-1:0] SCORE_BOTTOM = {1'b1, {(SCORE_BITS-1){1'b0}}};

	logic                         clk          = 1'b0;
	logic                         arst_n       = 1'b0;
	logic                         psel         = 1'b0;
	logic                         penable      = 1'b0;
	logic                         pwrite       = 1'b0;
	logic [PADDR_W-1:0]           paddr        = '0;
	logic [PDATA_W-1:0]           pwdata       = '0;
	logic [PDATA_W-1:0]           prdata;
	logic                         pready;
	logic                         in_valid     = 1'b0;
	logic                         in_ready;
	logic [ACT_W-1:0]             action       = '0;
	logic [IDX_W-1:0]             item_index   = '0;
	logic [IDX_W-1:0]             group_index  = '0;
	logic signed [SCORE_BITS-1:0] score_value  = '0;
	logic [IDX_W-1:0]             source_index = '0;
	logic                         out_valid;
	logic                         out_ready    = 1'b0;
	logic                         entry_filled;
	logic                         replaced;
	logic signed [SCORE_BITS-1:0] best_score;
	logic [IDX_W-1:0]             best_item;
	logic [IDX_W-1:0]             best_source;

	int fail_count;
	int pending_count;
	int checked_count;
	int cycle_count = 0;
	int sent_by_action [4] = '{0, 0, 0, 0};

	always #6 clk = ~clk;

	grouped_best_score_table #(
		.MAX_ITEMS  (ITEM_DEPTH),
		.MAX_GROUPS (GROUP_DEPTH),
		.SCORE_BITS (SCORE_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.item_index   (item_index),
		.group_index  (group_index),
		.score_value  (score_value),
		.source_index (source_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.entry_filled (entry_filled),
		.replaced     (replaced),
		.best_score   (best_score),
		.best_item    (best_item),
		.best_source  (best_source)
	);

	gbst_checker #(
		.ITEM_DEPTH  (ITEM_DEPTH),
		.GROUP_DEPTH (GROUP_DEPTH),
		.SCORE_BITS  (SCORE_BITS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.item_index    (item_index),
		.group_index   (group_index),
		.score_value   (score_value),
		.source_index  (source_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.entry_filled  (entry_filled),
		.replaced      (replaced),
		.best_score    (best_score),
		.best_item     (best_item),
		.best_source   (best_source),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: stall patterns of random length, plus one long hold-off
	initial begin
		int  pattern;
		int  stretch;
		bit  long_hold_done;
		long_hold_done = 1'b0;
		forever begin
			pattern = $urandom_range(0, 3);
			stretch = $urandom_range(5, 60);
			repeat (stretch) begin
				@(posedge clk);
				case (pattern)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 4) != 0);
				endcase
			end
			if (!long_hold_done && checked_count >= 300) begin
				long_hold_done = 1'b1;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					out_ready <= 1'b0;
				end
			end
		end
	end

	task automatic send_item(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] item,
			input logic [IDX_W-1:0] group, input logic signed [SCORE_BITS-1:0] score,
			input logic [IDX_W-1:0] source);
		in_valid     <= 1'b1;
		action       <= act;
		item_index   <= item;
		group_index  <= group;
		score_value  <= score;
		source_index <= source;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_by_action[act]++;
	endtask

	// stop offering and wait until every outstanding result has been checked
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= MODE_ADDR;
		pwdata  <= {{(PDATA_W-1){1'b0}}, mode};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [IDX_W-1:0]             item_pool [24];
		logic [IDX_W-1:0]             group_pool [8];
		logic [ACT_W-1:0]             act;
		logic [IDX_W-1:0]             it;
		logic [IDX_W-1:0]             gr;
		logic signed [SCORE_BITS-1:0] sc;
		int                           pick;
		int                           burst_left;
		int                           gap;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_mode(1'b1);

		// max mode: empty read, unmapped offer, unused action, fill, ties, remap
		send_item(ACT_READ, '0, '0, '0, '0);
		send_item(ACT_OFFER, '0, '0, SCORE_TOP, '1);
		send_item(ACT_UNUSED, '1, '1, SCORE_BOTTOM, '1);
		send_item(ACT_MAP, 12'd0, '1, '0, '0);
		send_item(ACT_MAP, '1, 12'd0, '1, '1);
		send_item(ACT_OFFER, 12'd0, '0, SCORE_BOTTOM, 12'd0);
		send_item(ACT_OFFER, 12'd0, '0, SCORE_BOTTOM, '1);
		send_item(ACT_OFFER, '1, '0, SCORE_TOP, '1);
		send_item(ACT_MAP, '1, '1, '0, '0);
		send_item(ACT_OFFER, '1, '0, SCORE_TOP, 12'd1);
		send_item(ACT_OFFER, 12'd0, '0, SCORE_TOP, 12'd2);
		send_item(ACT_MAP, 12'd1, '1, '0, '0);
		send_item(ACT_OFFER, 12'd1, '0, '0, 12'd3);
		send_item(ACT_READ, '0, '1, '0, '0);
		send_item(ACT_READ, '0, 12'd0, '0, '0);
		drain();
		write_mode(1'b0);

		// min mode on the same table
		send_item(ACT_OFFER, 12'd0, '0, '0, 12'd5);
		send_item(ACT_OFFER, 12'd1, '0, SCORE_BOTTOM, 12'd6);
		send_item(ACT_OFFER, 12'd0, '0, SCORE_BOTTOM, 12'd7);
		send_item(ACT_OFFER, 12'd1, '0, '1, 12'd8);
		send_item(ACT_READ, '0, '1, '0, '0);
		send_item(ACT_READ, '0, 12'd1, '0, '0);
		send_item(ACT_UNUSED, '0, '0, '0, '0);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			write_mode(phase % 2 == 0);
			// small pools so that offers hit mapped items and groups collide
			foreach (item_pool[i])
				item_pool[i] = IDX_W'($urandom_range(0, ITEM_DEPTH - 1));
			foreach (group_pool[i])
				group_pool[i] = IDX_W'($urandom_range(0, GROUP_DEPTH - 1));
			burst_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					if (gap > 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				burst_left--;

				it = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
						: item_pool[$urandom_range(0, 23)];
				gr = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
						: group_pool[$urandom_range(0, 7)];
				case ($urandom_range(0, 9))
					0, 1: begin
						case ($urandom_range(0, 3))
							0: sc = SCORE_TOP;
							1: sc = SCORE_BOTTOM;
							2: sc = '1;
							default: sc = '0;
						endcase
					end
					2, 3, 4: begin
						sc = SCORE_BITS'(int'($urandom_range(0, 16)) - 8);
					end
					default: sc = SCORE_BITS'($urandom);
				endcase

				pick = $urandom_range(0, 99);
				if (pick < 18)
					act = ACT_MAP;
				else if (pick < 75)
					act = ACT_OFFER;
				else if (pick < 95)
					act = ACT_READ;
				else
					act = ACT_UNUSED;
				send_item(act, it, gr, sc, IDX_W'($urandom));
			end
		end
		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d map writes, %0d score offers, %0d reads, %0d unused actions",
				sent_by_action[ACT_MAP], sent_by_action[ACT_OFFER],
				sent_by_action[ACT_READ], sent_by_action[ACT_UNUSED]);
		$display("Checked %0d results across max and min mode phases with output stalls",
				checked_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
